@@ design/masked_write_buffer_defines.svh @@
// Assertion macros shared by the masked write buffer modules.
`ifndef MASKED_WRITE_BUFFER_DEFINES_SVH
`define MASKED_WRITE_BUFFER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high.
`define MWB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("masked_write_buffer: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define MWB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("masked_write_buffer: next-cycle check failed");

`else

`define MWB_ASSERT_NOW(label, clk, rst, ante, cons)
`define MWB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/mwb_pkg.sv @@
// Shared types and codes of the masked write buffer.
`timescale 1ns / 1ps
`default_nettype none

package mwb_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_W        = 64;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_COMMIT = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   localparam logic [1:0] KIND_ADD_ACK = 2'd0;
   localparam logic [1:0] KIND_LOOKUP  = 2'd1;
   localparam logic [1:0] KIND_COMMIT  = 2'd2;
   localparam logic [1:0] KIND_DONE    = 2'd3;

   // Which result beat the datapath builds when told to load its output register.
   typedef enum logic [2:0] {
      SEL_ADD_ACK = 3'd0,
      SEL_HIT     = 3'd1,
      SEL_MISS    = 3'd2,
      SEL_COMMIT  = 3'd3,
      SEL_EMPTY   = 3'd4
   } sel_type;

   typedef struct packed {
      logic    item_load;
      logic    add_en;
      logic    clear_en;
      logic    idx_top;
      logic    idx_zero;
      logic    idx_dec;
      logic    idx_inc;
      logic    rd_en;
      logic    out_load;
      sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic idx_first;
      logic idx_last;
      logic match;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ design/mwb_ctrl.sv @@
// Controller state machine of the masked write buffer.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_write_buffer_defines.svh"

module mwb_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_opcode,
   input  wire mwb_pkg::status_type status,
   output mwb_pkg::cmd_type        cmd
);
   import mwb_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_CHECK = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   sel_type   sel_ff, sel_in;
   logic      is_lookup_ff, is_lookup_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      is_lookup_in = is_lookup_ff;
      cmd          = '0;
      cmd.out_sel  = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.item_load = 1'b1;
               is_lookup_in  = (op_type'(req_opcode) == OP_LOOKUP);
               case (op_type'(req_opcode))
                  OP_ADD: begin
                     cmd.add_en = 1'b1;
                     sel_in     = SEL_ADD_ACK;
                     state_in   = ST_EXEC;
                  end
                  OP_LOOKUP: begin
                     if (status.count_zero) begin
                        sel_in   = SEL_MISS;
                        state_in = ST_EXEC;
                     end else begin
                        cmd.idx_top = 1'b1;
                        state_in    = ST_READ;
                     end
                  end
                  OP_COMMIT: begin
                     if (status.count_zero) begin
                        sel_in   = SEL_EMPTY;
                        state_in = ST_EXEC;
                     end else begin
                        cmd.idx_zero = 1'b1;
                        state_in     = ST_READ;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.clear_en = 1'b1;
                     sel_in       = SEL_EMPTY;
                     state_in     = ST_EXEC;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (is_lookup_ff) begin
               if (status.match || status.idx_first) begin
                  cmd.out_sel = status.match ? SEL_HIT : SEL_MISS;
                  if (status.out_free) begin
                     cmd.out_load = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end else begin
                  // Older entry next: the search runs from newest to oldest.
                  cmd.idx_dec = 1'b1;
                  state_in    = ST_READ;
               end
            end else begin
               cmd.out_sel = SEL_COMMIT;
               if (status.out_free) begin
                  cmd.out_load = 1'b1;
                  if (status.idx_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.idx_inc = 1'b1;
                     state_in    = ST_READ;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SEL_ADD_ACK;
         is_lookup_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         is_lookup_ff <= is_lookup_in;
      end
   end

   `MWB_ASSERT_NOW(a_read_nonempty, clock, reset, state_ff == ST_READ, !status.count_zero)
   `MWB_ASSERT_NEXT(a_load_exit, clock, reset, cmd.out_load, $past(reset) || state_ff == ST_IDLE || state_ff == ST_READ)
   `MWB_ASSERT_NOW(a_check_no_accept, clock, reset, state_ff == ST_CHECK, !req_ready && !cmd.item_load)

endmodule

`default_nettype wire

@@ design/mwb_dpath.sv @@
// Datapath of the masked write buffer: entry memory, count, index and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_write_buffer_defines.svh"

module mwb_dpath #(
   parameter int DEPTH = mwb_pkg::DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [63:0]          req_word_address,
   input  wire logic [63:0]          req_write_value,
   input  wire logic [63:0]          req_bit_mask,
   input  wire logic [63:0]          req_memory_word,
   input  wire mwb_pkg::cmd_type     cmd,
   output mwb_pkg::status_type       status,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_reply_kind,
   output logic                      rsp_hit,
   output logic [63:0]               rsp_reply_data,
   output logic [63:0]               rsp_out_address,
   output logic [63:0]               rsp_out_mask,
   output logic                      rsp_overflow,
   output logic                      rsp_is_empty,
   output logic                      rsp_last
);
   import mwb_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [WORD_W-1:0] addr;
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] mask;
   } entry_type;

   entry_type         mem [DEPTH];
   entry_type         rd_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [WORD_W-1:0] addr_ff;
   logic [WORD_W-1:0] memw_ff;
   logic              ovf_ff;
   logic              full;
   logic [CNT_W-1:0]  count_m1;
   logic [CNT_W-1:0]  idx_next;
   logic [WORD_W-1:0] merged;

   logic              rsp_valid_ff;
   logic [1:0]        kind_ff;
   logic              hit_ff, ovf_out_ff, empty_ff, last_ff;
   logic [WORD_W-1:0] data_ff, oaddr_ff, omask_ff;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign count_m1 = count_ff - CNT_W'(1);
   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);

   assign status.count_zero = (count_ff == '0);
   assign status.idx_first  = (idx_ff == '0);
   assign status.idx_last   = (idx_next == count_ff);
   assign status.match      = (rd_ff.addr == addr_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // A zero mask means the stored word replaces memory entirely.
   assign merged = (rd_ff.mask == '0) ? rd_ff.value
                 : ((rd_ff.value & rd_ff.mask) | (memw_ff & ~rd_ff.mask));

   always_comb begin
      count_in = count_ff;
      if (cmd.clear_en) begin
         count_in = '0;
      end else if (cmd.add_en && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_top) begin
         idx_in = count_m1[IDX_W-1:0];
      end else if (cmd.idx_zero) begin
         idx_in = '0;
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - IDX_W'(1);
      end else if (cmd.idx_inc) begin
         idx_in = idx_next[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_en && !full) begin
         mem[count_ff[IDX_W-1:0]] <= '{addr: req_word_address, value: req_write_value,
                                      mask: req_bit_mask};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
      if (cmd.item_load) begin
         addr_ff <= req_word_address;
         memw_ff <= req_memory_word;
         ovf_ff  <= cmd.add_en && full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         hit_ff     <= 1'b0;
         data_ff    <= '0;
         oaddr_ff   <= '0;
         omask_ff   <= '0;
         ovf_out_ff <= 1'b0;
         last_ff    <= 1'b1;
         empty_ff   <= (count_ff == '0);
         case (cmd.out_sel)
            SEL_ADD_ACK: begin
               kind_ff    <= KIND_ADD_ACK;
               ovf_out_ff <= ovf_ff;
            end
            SEL_HIT: begin
               kind_ff <= KIND_LOOKUP;
               hit_ff  <= 1'b1;
               data_ff <= merged;
            end
            SEL_MISS: kind_ff <= KIND_LOOKUP;
            SEL_COMMIT: begin
               kind_ff  <= KIND_COMMIT;
               data_ff  <= rd_ff.value;
               oaddr_ff <= rd_ff.addr;
               omask_ff <= rd_ff.mask;
               empty_ff <= 1'b0;
               last_ff  <= status.idx_last;
            end
            SEL_EMPTY: kind_ff <= KIND_DONE;
            default:   kind_ff <= KIND_DONE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reply_kind  = kind_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_reply_data  = data_ff;
   assign rsp_out_address = oaddr_ff;
   assign rsp_out_mask    = omask_ff;
   assign rsp_overflow    = ovf_out_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_last        = last_ff;

   `MWB_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `MWB_ASSERT_NEXT(a_count_hold, clock, reset, !cmd.add_en && !cmd.clear_en, $past(reset) || count_ff == $past(count_ff))
   `MWB_ASSERT_NOW(a_load_free, clock, reset, cmd.out_load, status.out_free)

endmodule

`default_nettype wire

@@ design/masked_write_buffer.sv @@
// Top level of the masked write buffer: controller plus datapath.
// Add, clear and commit of an empty buffer pass through the execute state to the result beat.
// Lookup reads the newest entry first, then steps to older entries until a match or the oldest.
// Commit reads entries oldest first; the single memory read port sets the pace, a full output stalls.
// A new item is taken the cycle after the previous one loads its last beat.
// Synchronous reset empties the buffer and drops any pending beat; entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module masked_write_buffer #(
   parameter int DEPTH = mwb_pkg::DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [63:0] req_word_address,
   input  wire logic [63:0] req_write_value,
   input  wire logic [63:0] req_bit_mask,
   input  wire logic [63:0] req_memory_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_reply_kind,
   output logic             rsp_hit,
   output logic [63:0]      rsp_reply_data,
   output logic [63:0]      rsp_out_address,
   output logic [63:0]      rsp_out_mask,
   output logic             rsp_overflow,
   output logic             rsp_is_empty,
   output logic             rsp_last
);
   import mwb_pkg::*;

   // The controller sequences each operation; the datapath holds the entry memory,
   // the fill count, the scan index and the output register that carries each beat.
   cmd_type    cmd;
   status_type status;

   mwb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd)
   );

   // Entries are only read below the fill count, so the memory needs no clearing pass.
   mwb_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_word_address (req_word_address),
      .req_write_value  (req_write_value),
      .req_bit_mask     (req_bit_mask),
      .req_memory_word  (req_memory_word),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reply_kind   (rsp_reply_kind),
      .rsp_hit          (rsp_hit),
      .rsp_reply_data   (rsp_reply_data),
      .rsp_out_address  (rsp_out_address),
      .rsp_out_mask     (rsp_out_mask),
      .rsp_overflow     (rsp_overflow),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire
